FILE: hw/rtl/ascii_sentence_checksum_checker_assert.svh
// assertion macros shared by the checker rtl
// expects clk in the scope of each use, and rst_n for ASCC_ASSERT
`ifndef ASCII_SENTENCE_CHECKSUM_CHECKER_ASSERT_SVH
`define ASCII_SENTENCE_CHECKSUM_CHECKER_ASSERT_SVH

// checked only while out of reset
`define ASCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ascc assertion failed");

// checked on every edge, reset included
`define ASCC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ascc assertion failed");

`endif

FILE: hw/rtl/ascc_pkg.sv
// types and constants of the sentence checksum checker
// no dependencies
package ascc_pkg;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [7:0] MAX_LEN_RESET = 8'd255;

  localparam logic [2:0] VERDICT_VALID    = 3'd0;
  localparam logic [2:0] VERDICT_NO_START = 3'd1;
  localparam logic [2:0] VERDICT_NO_STAR  = 3'd2;
  localparam logic [2:0] VERDICT_MISMATCH = 3'd3;
  localparam logic [2:0] VERDICT_TOO_LONG = 3'd4;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_BODY  = 2'd1,
    PH_HEX   = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] verdict;
    logic [7:0] line_length;
    logic [7:0] checksum;
  } line_res_t;

  // hex digit decode: valid flag and 4-bit value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, b[3:0]};
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/ascc_in_stage.sv
// input register stage of the checker
// no dependencies
module ascc_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign in_ready = !valid_r || take;
  assign valid_o  = valid_r;
  assign byte_o   = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

FILE: hw/rtl/ascc_line_core.sv
// per-line parse state and verdict logic
// depends on ascc_pkg
module ascc_line_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           max_len,
  output ascc_pkg::line_res_t  res
);
  import ascc_pkg::*;

  logic [7:0] count_r, count_nxt;
  phase_t     phase_r, phase_nxt;
  logic       start_ok_r, start_ok_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] rsum_r, rsum_nxt;
  logic       ovf_r, ovf_nxt;
  logic [4:0] hd;
  logic [7:0] cnt_inc;

  always_comb begin
    cnt_inc      = count_r + 8'd1;
    hd           = hex_digit(rx_byte);
    phase_nxt    = phase_r;
    start_ok_nxt = start_ok_r;
    xor_nxt      = xor_r;
    rsum_nxt     = rsum_r;
    ovf_nxt      = ovf_r;
    case (phase_r)
      PH_FIRST: begin
        start_ok_nxt = (rx_byte == CH_DOLLAR);
        phase_nxt    = PH_BODY;
      end
      PH_BODY: begin
        if (rx_byte == CH_STAR) begin
          phase_nxt = PH_HEX;
        end else begin
          xor_nxt = xor_r ^ rx_byte;
        end
      end
      PH_HEX: begin
        if (!hd[4]) begin
          phase_nxt = PH_DONE;
        end else begin
          if (rsum_r[7:4] != 4'd0) begin
            ovf_nxt = 1'b1;
          end
          rsum_nxt = {rsum_r[3:0], hd[3:0]};
        end
      end
      default: ;
    endcase

    res.hit         = 1'b0;
    res.verdict     = VERDICT_VALID;
    res.line_length = cnt_inc;
    res.checksum    = xor_nxt;
    if (rx_byte == CH_NEWLINE) begin
      res.hit = 1'b1;
      if (!start_ok_nxt) begin
        res.verdict = VERDICT_NO_START;
      end else if (phase_nxt == PH_BODY) begin
        res.verdict = VERDICT_NO_STAR;
      end else if (ovf_nxt || rsum_nxt != xor_nxt) begin
        res.verdict = VERDICT_MISMATCH;
      end
    end else if (cnt_inc >= max_len) begin
      res.hit     = 1'b1;
      res.verdict = VERDICT_TOO_LONG;
    end

    count_nxt = cnt_inc;
    if (res.hit) begin
      count_nxt    = 8'd0;
      phase_nxt    = PH_FIRST;
      start_ok_nxt = 1'b0;
      xor_nxt      = 8'd0;
      rsum_nxt     = 8'd0;
      ovf_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= 8'd0;
      phase_r    <= PH_FIRST;
      start_ok_r <= 1'b0;
      xor_r      <= 8'd0;
      rsum_r     <= 8'd0;
      ovf_r      <= 1'b0;
    end else if (fire) begin
      count_r    <= count_nxt;
      phase_r    <= phase_nxt;
      start_ok_r <= start_ok_nxt;
      xor_r      <= xor_nxt;
      rsum_r     <= rsum_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

endmodule

FILE: hw/rtl/ascii_sentence_checksum_checker.sv
// top level of the sentence checksum checker: config, stages, result register
// depends on ascc_pkg, ascc_in_stage, ascc_line_core and the assert header
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid, in_ready, in_rx_byte       | input item
//   out     | out_valid, out_ready, out_verdict,   | result item
//           | out_line_length, out_computed_checksum
//   cfg     | cfg_wr_en, cfg_wr_data               | write only
//
// one byte per cycle when not stalled; each byte is registered in the input register and
// the line state update plus verdict is one combinational step into the result register
// a result is valid once its byte has moved from the input register into the result register
// reset clears the line state, the stage valids and sets the length limit to 255
// a byte is held in the input register while a result waits and out_ready is low
`include "ascii_sentence_checksum_checker_assert.svh"
module ascii_sentence_checksum_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_verdict,
  output logic [7:0] out_line_length,
  output logic [7:0] out_computed_checksum,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import ascc_pkg::*;

  logic       max_len_r;
  logic [7:0] max_len_val_r;
  logic       st_valid;
  logic [7:0] st_byte;
  logic       fire;
  line_res_t  res;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] verdict_r;
  logic [7:0] len_r;
  logic [7:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_val_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_val_r <= cfg_wr_data;
    end
  end

  // marks that a limit was loaded at least once since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 1'b0;
    end else if (cfg_wr_en) begin
      max_len_r <= 1'b1;
    end
  end

  assign fire = st_valid && (!out_valid_r || out_ready);

  ascc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_rx_byte),
    .take     (fire),
    .valid_o  (st_valid),
    .byte_o   (st_byte)
  );

  ascc_line_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (st_byte),
    .max_len (max_len_val_r),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && res.hit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.hit) begin
      verdict_r <= res.verdict;
      len_r     <= res.line_length;
      sum_r     <= res.checksum;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_verdict           = verdict_r;
  assign out_line_length       = len_r;
  assign out_computed_checksum = sum_r;

  `ASCC_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid_r)
  `ASCC_ASSERT(a_verdict_range, out_valid_r |-> verdict_r <= VERDICT_TOO_LONG)
  `ASCC_ASSERT(a_len_nonzero, out_valid_r |-> len_r != 8'd0)
  `ASCC_ASSERT(a_too_long_len,
    (out_valid_r && verdict_r == VERDICT_TOO_LONG && max_len_r) |->
      (len_r >= max_len_val_r || max_len_val_r <= 8'd1))
  `ASCC_ASSERT(a_stall_holds_byte,
    (st_valid && !fire) |=> (st_valid && $stable(st_byte)))

endmodule
